@@ sv/gcdt_pkg.sv @@
package gcdt_pkg;

  // Angles in degrees, Q.20, carried in 30-bit signed words
  localparam logic signed [29:0] DEG_90  = 30'sd94371840;
  localparam logic signed [29:0] DEG_180 = 30'sd188743680;
  localparam logic signed [29:0] DEG_360 = 30'sd377487360;

  // pi/180 in Q.40, split for two narrow partial products
  localparam logic [63:0] DEG2RAD_Q40 = 64'd19190098069;
  localparam int          K_SPLIT     = 20;
  localparam logic [14:0] K_HI        = 15'(DEG2RAD_Q40 >> K_SPLIT);
  localparam logic [19:0] K_LO        = 20'(DEG2RAD_Q40 & ((64'd1 << K_SPLIT) - 64'd1));

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [32:0] Q30_HI      = 33'sd1073741824;
  localparam logic signed [32:0] Q30_LO      = -33'sd1073741824;
  localparam logic [30:0]        Q30_ONE     = 31'd1073741824;

  localparam int          SQRT_STEPS = 31;
  localparam logic [29:0] DIST_MAX   = 30'h3FFF_FFFF;

  // Configuration register indexes
  localparam int          CFG_IDX_W  = 2;
  localparam logic [1:0]  CFG_RADIUS = 2'd0;
  localparam logic [1:0]  CFG_TPKM   = 2'd1;

  localparam logic [15:0] RADIUS_RST = 16'd6371;
  localparam logic [15:0] TPKM_RST   = 16'd15360;

  // Arctangent of 2^-i in Q.30
  function automatic logic [30:0] atan_q30(input int unsigned i);
    logic [30:0] v;
    v = '0;
    unique case (i)
      0:  v = 31'd843314857;
      1:  v = 31'd497837829;
      2:  v = 31'd263043837;
      3:  v = 31'd133525159;
      4:  v = 31'd67021687;
      5:  v = 31'd33543516;
      6:  v = 31'd16775851;
      7:  v = 31'd8388437;
      8:  v = 31'd4194283;
      9:  v = 31'd2097149;
      10: v = 31'd1048576;
      11: v = 31'd524288;
      default: v = (i <= 30) ? (31'd1 << (30 - i)) : '0;
    endcase
    return v;
  endfunction

  // Clamp to [-1, 1] in Q.30
  function automatic logic signed [31:0] clamp_q30(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = v;
    if (v > Q30_HI) begin
      r = Q30_HI;
    end else if (v < Q30_LO) begin
      r = Q30_LO;
    end
    return 32'(r);
  endfunction

endpackage

@@ sv/great_circle_distance_and_time.sv @@
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | lat_a_i lon_a_i lat_b_i lon_b_i
// out     | output    | out_valid_o / out_stall_i  | distance_o travel_time_o
// cfg     | input     | cfg_we_i                   | cfg_idx_i cfg_wdata_i
//
// One transaction enters per cycle while in_stall_o is low; a result reaches
// the output register after two CORDIC chains and a 31-step square root.
// Reset (rst_ni low, asynchronous) clears the valid bits and loads the
// configuration defaults. A stall on out freezes the pipeline only while the
// last stage and the output register both hold results; bubbles still drain.
module great_circle_distance_and_time_core #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [27:0]             lat_a_i,
  input  logic signed [28:0]             lon_a_i,
  input  logic signed [27:0]             lat_b_i,
  input  logic signed [28:0]             lon_b_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [29:0]                    distance_o,
  output logic [31:0]                    travel_time_o,
  input  logic                           cfg_we_i,
  input  logic [gcdt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                    cfg_wdata_i
);

  localparam int N       = CORDIC_STAGES;
  localparam int SQ      = gcdt_pkg::SQRT_STEPS;
  // Stage positions in the valid shift line
  localparam int V_ROT0  = 4;
  localparam int V_TRIG  = V_ROT0 + N + 1;
  localparam int V_SQ0   = V_TRIG + 3;
  localparam int V_VEC0  = V_SQ0 + SQ;
  localparam int V_D1    = V_VEC0 + N + 1;
  localparam int NSTG    = V_D1 + 3;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] radius_q, tpkm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= gcdt_pkg::RADIUS_RST;
      tpkm_q   <= gcdt_pkg::TPKM_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gcdt_pkg::CFG_RADIUS) begin
        radius_q <= cfg_wdata_i;
      end else if (cfg_idx_i == gcdt_pkg::CFG_TPKM) begin
        tpkm_q <= cfg_wdata_i;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: advance unless the last stage has a result with nowhere
  // to go. Valid bits shift with the data.
  // ---------------------------------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic            out_valid_q;
  logic            adv;
  logic            out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = !(vld_q[NSTG-1] && !out_free);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[NSTG-2:0], in_valid_i};
      end
      if (out_free) begin
        out_valid_q <= vld_q[NSTG-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Angle preparation. Lanes: 0 dlat, 1 dlon, 2 lat_a, 3 lat_b.
  // ---------------------------------------------------------------------
  logic signed [29:0] ang_q  [4];
  logic signed [29:0] wrap_q [4];
  logic signed [29:0] wrap_d [4];
  logic [26:0]        mag_q  [4];
  logic [26:0]        mag_d  [4];
  logic [3:0]         neg_q, neg_d, fld_q, fld_d;
  logic [41:0]        pph_q  [4];
  logic [46:0]        ppl_q  [4];
  logic [3:0]         ppn_q, ppf_q;
  logic signed [32:0] z0_d   [4];

  // Wrap to [-180, 180) degrees; one correction covers the input range
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      wrap_d[l] = ang_q[l];
      if (ang_q[l] >= gcdt_pkg::DEG_180) begin
        wrap_d[l] = ang_q[l] - gcdt_pkg::DEG_360;
      end else if (ang_q[l] < -gcdt_pkg::DEG_180) begin
        wrap_d[l] = ang_q[l] + gcdt_pkg::DEG_360;
      end
    end
  end

  // Fold into [-90, 90]; the cosine changes sign on a fold
  always_comb begin
    logic signed [29:0] r;
    logic signed [29:0] ar;
    for (int l = 0; l < 4; l++) begin
      r        = wrap_q[l];
      fld_d[l] = 1'b0;
      if (wrap_q[l] > gcdt_pkg::DEG_90) begin
        r        = gcdt_pkg::DEG_180 - wrap_q[l];
        fld_d[l] = 1'b1;
      end else if (wrap_q[l] < -gcdt_pkg::DEG_90) begin
        r        = -gcdt_pkg::DEG_180 - wrap_q[l];
        fld_d[l] = 1'b1;
      end
      neg_d[l] = r[29];
      ar       = r[29] ? -r : r;
      mag_d[l] = ar[26:0];
    end
  end

  // Radians in Q.30, rounded half away from zero
  always_comb begin
    logic [61:0]        s;
    logic signed [32:0] zs;
    for (int l = 0; l < 4; l++) begin
      s       = (62'(pph_q[l]) << gcdt_pkg::K_SPLIT) + 62'(ppl_q[l]) + (62'd1 << 29);
      zs      = $signed({1'b0, s[61:30]});
      z0_d[l] = ppn_q[l] ? -zs : zs;
    end
  end

  logic signed [32:0] rx_q [0:N][4];
  logic signed [32:0] ry_q [0:N][4];
  logic signed [32:0] rz_q [0:N][4];
  logic [3:0]         rf_q [0:N];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang_q[0] <= 30'(lat_b_i) - 30'(lat_a_i);
      ang_q[1] <= 30'(lon_b_i) - 30'(lon_a_i);
      ang_q[2] <= 30'(lat_a_i);
      ang_q[3] <= 30'(lat_b_i);
      wrap_q   <= wrap_d;
      mag_q    <= mag_d;
      neg_q    <= neg_d;
      fld_q    <= fld_d;
      for (int l = 0; l < 4; l++) begin
        pph_q[l] <= 42'(mag_q[l]) * 42'(gcdt_pkg::K_HI);
        ppl_q[l] <= 47'(mag_q[l]) * 47'(gcdt_pkg::K_LO);
        rx_q[0][l] <= gcdt_pkg::CORDIC_GAIN;
        ry_q[0][l] <= '0;
        rz_q[0][l] <= z0_d[l];
      end
      ppn_q    <= neg_q;
      ppf_q    <= fld_q;
      rf_q[0]  <= ppf_q;
    end
  end

  // ---------------------------------------------------------------------
  // Rotation CORDIC, one micro-rotation per stage, four lanes
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < N; k++) begin : g_rot
    logic signed [32:0] at;
    assign at = 33'(gcdt_pkg::atan_q30(k));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int l = 0; l < 4; l++) begin
          if (!rz_q[k][l][32]) begin
            rx_q[k+1][l] <= rx_q[k][l] - (ry_q[k][l] >>> k);
            ry_q[k+1][l] <= ry_q[k][l] + (rx_q[k][l] >>> k);
            rz_q[k+1][l] <= rz_q[k][l] - at;
          end else begin
            rx_q[k+1][l] <= rx_q[k][l] + (ry_q[k][l] >>> k);
            ry_q[k+1][l] <= ry_q[k][l] - (rx_q[k][l] >>> k);
            rz_q[k+1][l] <= rz_q[k][l] + at;
          end
        end
        rf_q[k+1] <= rf_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Haversine-style sum: a = sin^2(dlat) + cos(a)cos(b)sin^2(dlon)
  // ---------------------------------------------------------------------
  logic signed [31:0] trig_q [4];
  logic signed [31:0] trig_d [4];
  logic [30:0]        sqlat_q, sqlon_q, sqlat2_q;
  logic signed [31:0] cc_q;
  logic signed [63:0] ccs_q;
  logic [30:0]        sqlat_d, sqlon_d;
  logic signed [31:0] cc_d;
  logic [60:0]        rema_d, remb_d;

  always_comb begin
    logic signed [31:0] ca, cb;
    ca        = gcdt_pkg::clamp_q30(rx_q[N][2]);
    cb        = gcdt_pkg::clamp_q30(rx_q[N][3]);
    trig_d[0] = gcdt_pkg::clamp_q30(ry_q[N][0]);
    trig_d[1] = gcdt_pkg::clamp_q30(ry_q[N][1]);
    trig_d[2] = rf_q[N][2] ? -ca : ca;
    trig_d[3] = rf_q[N][3] ? -cb : cb;
  end

  always_comb begin
    logic signed [63:0] p0, p1, p2;
    p0      = 64'(trig_q[0]) * 64'(trig_q[0]);
    p1      = 64'(trig_q[1]) * 64'(trig_q[1]);
    p2      = 64'(trig_q[2]) * 64'(trig_q[3]);
    sqlat_d = p0[60:30];
    sqlon_d = p1[60:30];
    cc_d    = p2[61:30];
  end

  // Clamp a to [0, 1] and form both radicands
  always_comb begin
    logic signed [33:0] t;
    logic [30:0]        a;
    t = $signed({3'b000, sqlat2_q}) + ccs_q[63:30];
    if (t[33]) begin
      a = '0;
    end else if (t > $signed({3'b000, gcdt_pkg::Q30_ONE})) begin
      a = gcdt_pkg::Q30_ONE;
    end else begin
      a = t[30:0];
    end
    rema_d = {a[30:0], 30'd0};
    remb_d = {gcdt_pkg::Q30_ONE - a, 30'd0};
  end

  logic [60:0] sra_q [0:SQ];
  logic [60:0] srb_q [0:SQ];
  logic [30:0] qa_q  [0:SQ];
  logic [30:0] qb_q  [0:SQ];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      trig_q    <= trig_d;
      sqlat_q   <= sqlat_d;
      sqlon_q   <= sqlon_d;
      cc_q      <= cc_d;
      sqlat2_q  <= sqlat_q;
      ccs_q     <= 64'(cc_q) * $signed({33'd0, sqlon_q});
      sra_q[0]  <= rema_d;
      srb_q[0]  <= remb_d;
      qa_q[0]   <= '0;
      qb_q[0]   <= '0;
    end
  end

  // ---------------------------------------------------------------------
  // Square roots, one result bit per stage (remainder form)
  // ---------------------------------------------------------------------
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam int B = SQ - 1 - j;
    logic [61:0] ta, tb;
    assign ta = (62'(qa_q[j]) << (B + 1)) | (62'd1 << (2 * B));
    assign tb = (62'(qb_q[j]) << (B + 1)) | (62'd1 << (2 * B));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (62'(sra_q[j]) >= ta) begin
          sra_q[j+1] <= 61'(62'(sra_q[j]) - ta);
          qa_q[j+1]  <= qa_q[j] | (31'd1 << B);
        end else begin
          sra_q[j+1] <= sra_q[j];
          qa_q[j+1]  <= qa_q[j];
        end
        if (62'(srb_q[j]) >= tb) begin
          srb_q[j+1] <= 61'(62'(srb_q[j]) - tb);
          qb_q[j+1]  <= qb_q[j] | (31'd1 << B);
        end else begin
          srb_q[j+1] <= srb_q[j];
          qb_q[j+1]  <= qb_q[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Vectoring CORDIC: c = atan2(sqrt(a), sqrt(1-a))
  // ---------------------------------------------------------------------
  logic signed [33:0] vx_q [1:N];
  logic signed [33:0] vy_q [1:N];
  logic signed [32:0] vz_q [1:N];

  for (genvar k = 0; k < N; k++) begin : g_vec
    logic signed [33:0] xi, yi;
    logic signed [32:0] zi;
    logic signed [32:0] at;
    assign at = 33'(gcdt_pkg::atan_q30(k));

    if (k == 0) begin : g_src
      assign xi = $signed({3'b000, qb_q[SQ]});
      assign yi = $signed({3'b000, qa_q[SQ]});
      assign zi = '0;
    end else begin : g_src
      assign xi = vx_q[k];
      assign yi = vy_q[k];
      assign zi = vz_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!yi[33] && (yi != '0)) begin
          vx_q[k+1] <= xi + (yi >>> k);
          vy_q[k+1] <= yi - (xi >>> k);
          vz_q[k+1] <= zi + at;
        end else begin
          vx_q[k+1] <= xi - (yi >>> k);
          vy_q[k+1] <= yi + (xi >>> k);
          vz_q[k+1] <= zi - at;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Scale to km and seconds
  // ---------------------------------------------------------------------
  logic [47:0] d1_prod_q;
  logic [34:0] d2_dist_q, d3_dist_q;
  logic [50:0] d3_tprod_q;
  logic [31:0] c_pos;
  logic [48:0] rnd;

  assign c_pos = vz_q[N][32] ? '0 : vz_q[N][31:0];
  assign rnd   = 49'(d1_prod_q) + (49'd1 << 13);

  logic [29:0] distance_q;
  logic [31:0] travel_time_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_prod_q  <= 48'(radius_q) * 48'(c_pos);
      d2_dist_q  <= rnd[48:14];
      d3_dist_q  <= d2_dist_q;
      d3_tprod_q <= 51'(tpkm_q) * 51'(d2_dist_q);
    end
    if (out_free && vld_q[NSTG-1]) begin
      // Saturate the distance; the time field can never exceed 32 bits
      distance_q    <= (d3_dist_q > 35'(gcdt_pkg::DIST_MAX)) ? gcdt_pkg::DIST_MAX
                                                             : d3_dist_q[29:0];
      travel_time_q <= 32'(d3_tprod_q[50:24]);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_o    = distance_q;
  assign travel_time_o = travel_time_q;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSTG-1] && !adv) |=> (vld_q[NSTG-1] && $stable(d3_dist_q)))
    else $error("last stage lost its transaction during a stall");

  a_out_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSTG-1] && adv) |=> out_valid_o)
    else $error("finished transaction did not reach the output register");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int STAGES    = 24;
  localparam int LATENCY   = 2 * STAGES + 44;
  localparam int N_RANDOM  = 800;
  localparam longint CYCLE_LIMIT = 400000;

  localparam longint LAT_MAX = 94371840;
  localparam longint LON_MAX = 188743680;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [27:0] lat_a_i;
  logic signed [28:0] lon_a_i;
  logic signed [27:0] lat_b_i;
  logic signed [28:0] lon_b_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [29:0]        distance_o;
  logic [31:0]        travel_time_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [15:0]        cfg_wdata_i;

  typedef struct packed {
    logic [29:0] distance;
    logic [31:0] travel_time;
  } leg_t;

  typedef struct {
    longint lat_a, lon_a, lat_b, lon_b;
    bit     known;      // expected values typed in below
    longint distance, travel_time;
  } route_row_t;

  leg_t   legs_due[$];
  logic [15:0] radius_sh, tpkm_sh;
  int     mismatches;
  int     legs_checked;
  longint cycle_cnt = 0;
  bit     hold_sink;    // long receiver hold-off requested
  bit     quiet;        // no idling near the end

  great_circle_distance_and_time_core #(.CORDIC_STAGES(STAGES)) DUT (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Keep a cycle count and end the run if it ever runs away.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor: fixed-point haversine-like arc and travel time
  // ---------------------------------------------------------------------
  function automatic longint asr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_step(int i);
    if (i < 31) return longint'(gcdt_pkg::atan_q30(i));
    return 0;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Sine and cosine of an angle in Q.20 degrees, both Q.30.
  task automatic sin_cos(input longint d, output longint s, output longint c);
    longint r, x, y, z, dx, dy, mag;
    bit flip;
    r = d % 377487360;
    flip = 0;
    if (r < 0) r += 377487360;
    if (r >= 188743680) r -= 377487360;
    if (r > 94371840) begin
      r = 188743680 - r; flip = 1;
    end else if (r < -94371840) begin
      r = -188743680 - r; flip = 1;
    end
    mag = r < 0 ? -r : r;
    // mag < 2^27 and the constant < 2^35: product fits in 63 bits
    z = (mag * 64'sd19190098069 + (64'sd1 << 29)) >>> 30;
    if (r < 0) z = -z;
    x = 652032874;
    y = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = asr_floor(y, i);
      dy = asr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    x = clip(x, -(64'sd1 << 30), 64'sd1 << 30);
    y = clip(y, -(64'sd1 << 30), 64'sd1 << 30);
    s = y;
    c = flip ? -x : x;
  endtask

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint arc_angle(longint yin, longint xin);
    longint x, y, z, dx, dy;
    x = xin; y = yin; z = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = asr_floor(y, i);
      dy = asr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    return z < 0 ? 0 : z;
  endfunction

  task automatic predict_leg(input longint la, lo_a, lb, lo_b, output leg_t leg);
    longint s_dlat, c_dlat, s_dlon, c_dlon, s_a, c_a, s_b, c_b;
    longint sq_lat, sq_lon, cc, a, arc;
    longint unsigned ra, rb, dist_raw, tim;
    sin_cos(lb - la, s_dlat, c_dlat);
    sin_cos(lo_b - lo_a, s_dlon, c_dlon);
    sin_cos(la, s_a, c_a);
    sin_cos(lb, s_b, c_b);
    sq_lat = (s_dlat * s_dlat) >>> 30;
    sq_lon = (s_dlon * s_dlon) >>> 30;
    cc = (c_a * c_b) >>> 30;
    a = clip(sq_lat + ((cc * sq_lon) >>> 30), 0, 64'sd1 << 30);
    ra = int_sqrt(longint'(a) << 30);
    rb = int_sqrt(((64'sd1 << 30) - a) << 30);
    arc = arc_angle(ra, rb);
    dist_raw = (longint'(radius_sh) * arc + (64'd1 << 13)) >> 14;
    tim = (longint'(tpkm_sh) * dist_raw) >> 24;
    leg.distance = dist_raw > 64'd1073741823 ? 30'h3FFF_FFFF : dist_raw[29:0];
    leg.travel_time = tim > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : tim[31:0];
  endtask

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gcdt_pkg::CFG_RADIUS) radius_sh = val;
    else if (idx == gcdt_pkg::CFG_TPKM) tpkm_sh = val;
  endtask

  // Offer one transaction from a falling edge; return at the falling edge
  // after it was taken, with valid left high for the next one.
  // Expected value is queued at acceptance.
  task automatic send_route(input longint la, lo_a, lb, lo_b,
                            input bit known, input leg_t typed);
    leg_t leg;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    lat_a_i <= 28'(la);
    lon_a_i <= 29'(lo_a);
    lat_b_i <= 28'(lb);
    lon_b_i <= 29'(lo_b);
    // predict on the sign-extended field values actually driven
    predict_leg(longint'($signed(28'(la))), longint'($signed(29'(lo_a))),
                longint'($signed(28'(lb))), longint'($signed(29'(lo_b))), leg);
    if (known && leg !== typed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Predictor disagrees with typed value: %h vs %h", leg, typed);
    end
    do @(posedge clk_i); while (in_stall_o);
    legs_due.push_back(leg);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (legs_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic longint rand_span(longint m);
    return longint'($urandom_range(0, 2 * m)) - m;
  endfunction

  // Random pair: mostly in range, some raw bit patterns, some near points.
  task automatic send_random();
    longint la, lo_a, lb, lo_b;
    int kind;
    kind = $urandom_range(0, 9);
    la = rand_span(LAT_MAX);
    lo_a = rand_span(LON_MAX);
    if (kind < 2) begin
      lb = la + rand_span(4096);
      lo_b = lo_a + rand_span(4096);
    end else if (kind == 2) begin
      la = $signed(28'($urandom));
      lo_a = $signed(29'($urandom));
      lb = $signed(28'($urandom));
      lo_b = $signed(29'($urandom));
    end else if (kind == 3) begin
      lb = -la;
      lo_b = lo_a + ((lo_a < 0) ? LON_MAX : -LON_MAX);
    end else begin
      lb = rand_span(LAT_MAX);
      lo_b = rand_span(LON_MAX);
    end
    send_route(la, lo_a, lb, lo_b, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off
  // ---------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        out_stall_i <= 1'b1;
        repeat (3 * LATENCY) @(negedge clk_i);
        hold_sink = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each delivered result with the oldest expectation.
  always @(posedge clk_i) begin
    leg_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (legs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h %h", distance_o, travel_time_o);
      end else begin
        want = legs_due.pop_front();
        legs_checked++;
        if (distance_o !== want.distance || travel_time_o !== want.travel_time) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: distance exp %0d got %0d, time exp %0d got %0d",
                     legs_checked, want.distance, distance_o,
                     want.travel_time, travel_time_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  route_row_t routes[] = '{
    // same point: arc down to the CORDIC residue
    '{0, 0, 0, 0, 0, 0, 0},
    '{LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, 0, 0, 0},
    '{-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 0, 0, 0},
    '{LAT_MAX, 0, -LAT_MAX, 0, 0, 0, 0},
    '{0, -LON_MAX, 0, LON_MAX, 0, 0, 0},
    '{0, 0, 0, LON_MAX, 0, 0, 0},
    '{0, 0, 0, LON_MAX / 2, 0, 0, 0},
    '{0, 0, LAT_MAX / 2, 0, 0, 0, 0},
    '{1, 0, 0, 1, 0, 0, 0},
    '{-134217728, -268435456, 134217727, 268435455, 0, 0, 0},
    '{134217727, 268435455, -134217728, -268435456, 0, 0, 0},
    '{-134217728, 0, -134217728, 0, 0, 0, 0},
    '{50 << 20, 8 << 20, -34 << 20, -58 << 20, 0, 0, 0},
    '{LAT_MAX, 7, LAT_MAX, -LON_MAX + 3, 0, 0, 0},
    '{-1, -1, 1, 1, 0, 0, 0}
  };

  initial begin
    leg_t typed;
    route_row_t r;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    lat_a_i = '0; lon_a_i = '0; lat_b_i = '0; lon_b_i = '0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    mismatches = 0; legs_checked = 0;
    hold_sink = 0; quiet = 0;
    radius_sh = gcdt_pkg::RADIUS_RST;
    tpkm_sh = gcdt_pkg::TPKM_RST;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed table at reset settings.
    foreach (routes[k]) begin
      r = routes[k];
      typed.distance = 30'(r.distance);
      typed.travel_time = 32'(r.travel_time);
      send_route(r.lat_a, r.lon_a, r.lat_b, r.lon_b, r.known, typed);
    end
    wait_drained();

    // Extreme settings: biggest radius and rate (the distance saturates), zero ones vanish.
    write_reg(gcdt_pkg::CFG_RADIUS, 16'hFFFF);
    write_reg(gcdt_pkg::CFG_TPKM, 16'hFFFF);
    write_reg(2'd3, 16'h0001);   // unmapped index, ignored
    send_route(LAT_MAX, 0, -LAT_MAX, 0, 0, '0);
    send_route(0, -LON_MAX, 0, LON_MAX, 0, '0);
    wait_drained();
    write_reg(gcdt_pkg::CFG_RADIUS, 16'd0);
    typed = '0;
    send_route(LAT_MAX, 0, -LAT_MAX, 0, 1, typed);
    wait_drained();
    write_reg(gcdt_pkg::CFG_RADIUS, 16'd1);
    write_reg(gcdt_pkg::CFG_TPKM, 16'd0);
    send_route(0, 0, 0, LON_MAX / 3, 0, '0);
    wait_drained();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(gcdt_pkg::CFG_RADIUS,
                ph == 0 ? gcdt_pkg::RADIUS_RST : 16'($urandom_range(1, 65535)));
      write_reg(gcdt_pkg::CFG_TPKM, 16'($urandom));
      if (ph == 1) hold_sink = 1'b1;   // fill the pipe against a held receiver
      if (ph == 3) quiet = 1'b1;
      for (int n = 0; n < N_RANDOM / 4; n++) send_random();
      wait_drained();
    end

    repeat (LATENCY + 10) @(negedge clk_i);
    $display("Checked %0d results over directed extremes and %0d random pairs",
             legs_checked, N_RANDOM);
    $display("Register settings swept: reset, zero, one and full-scale values");
    if (mismatches == 0 && legs_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
